>>> hdl/vbhi_pkg.sv
// Shared types and constants for the variable bin histogram integral block.
// No dependencies; compiled first.
package vbhi_pkg;

   localparam int FUNC_W  = 2;
   localparam int INDEX_W = 5;
   localparam int DATA_W  = 32;
   localparam int BIN_W   = 5;
   localparam int SUM_W   = 36;
   localparam int NORM_W  = 48;
   localparam int COUNT_W = 5;

   typedef enum logic [FUNC_W-1:0] {
      FN_EDGE_WR = 2'd0,
      FN_BIN_WR  = 2'd1,
      FN_QUERY   = 2'd2,
      FN_CLEAR   = 2'd3
   } func_type;

endpackage

>>> hdl/vbhi_req_if.sv
// Request channel (valid/ready) for the histogram block.
// Depends on vbhi_pkg for field widths.
interface vbhi_req_if;
   import vbhi_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [FUNC_W-1:0]         func;
   logic [INDEX_W-1:0]        slot_index;
   logic signed [DATA_W-1:0]  data_value;
   logic signed [DATA_W-1:0]  lower_bound;
   logic signed [DATA_W-1:0]  upper_bound;

   modport source (output valid, func, slot_index, data_value, lower_bound, upper_bound,
                   input ready);
   modport sink   (input valid, func, slot_index, data_value, lower_bound, upper_bound,
                   output ready);
endinterface

>>> hdl/vbhi_rsp_if.sv
// Response channel (valid/ready) for the histogram block.
// Depends on vbhi_pkg for field widths.
interface vbhi_rsp_if;
   import vbhi_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [SUM_W-1:0]   range_sum;
   logic [BIN_W-1:0]          low_bin;
   logic [BIN_W-1:0]          high_bin;
   logic signed [NORM_W-1:0]  norm_total;

   modport source (output valid, range_sum, low_bin, high_bin, norm_total, input ready);
   modport sink   (input valid, range_sum, low_bin, high_bin, norm_total, output ready);
endinterface

>>> hdl/variable_bin_histogram_integral_top.sv
// Top level of the variable bin histogram integral block.
// Depends on vbhi_pkg, vbhi_req_if and vbhi_rsp_if.
//
// Usage:
//   req_bus carries one command per transfer: edge write, bin write, range
//   query or clear. rsp_bus returns exactly one result per command, in order.
//   csr_wr_en/csr_wr_data load the edge count; write it only while idle.
// Command flow:
//   edge write goes straight to the result; bin write first reads the old bin.
//   query: the lower, then the upper bound is located among the edges, then
//     the bins between them are summed, one edge or one bin per cycle through
//     the single read port of each table. A zero edge count skips the search.
//   clear: a sweep of the regular bins to update the
//     normalization; bins are then zeroed at once through per-entry valid bits.
// One command is in flight at a time; the next one is taken while a result
//   still waits in the output register.
// Reset: bins read as zero, normalization zero, edge count 16, edge table
//   undefined until written. No clearing pass is needed.
// Stall: a result is held in the output register until taken; the block
//   then waits with the next result finished.
module variable_bin_histogram_integral_top #(
   parameter int MAX_EDGES  = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   vbhi_req_if.sink                       req_bus,
   vbhi_rsp_if.source                     rsp_bus,
   input  logic                           csr_wr_en,
   input  logic [vbhi_pkg::COUNT_W-1:0]   csr_wr_data
);
   import vbhi_pkg::*;

   localparam int VW  = (VALUE_BITS < DATA_W) ? VALUE_BITS : DATA_W;
   localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int BAW = $clog2(MAX_EDGES + 1);
   localparam int CAP = (MAX_EDGES < 31) ? MAX_EDGES : 31;
   localparam logic [COUNT_W-1:0] CAP_C = COUNT_W'(CAP);

   typedef enum logic [2:0] {
      ST_IDLE, ST_BIN, ST_LOC, ST_SUM, ST_CLR, ST_DONE
   } state_type;

   logic [VW-1:0] edge_mem [MAX_EDGES];
   logic [VW-1:0] bin_mem  [MAX_EDGES+1];
   logic [MAX_EDGES:0] bin_valid_ff;

   state_type state_ff, state_in;
   logic [COUNT_W-1:0] edges_used_ff;
   logic [COUNT_W-1:0] n_cur, n_ff, n_in;
   logic [VW-1:0] val_ff, val_in;
   logic regular_ff, regular_in;
   logic [BAW-1:0] baddr_ff, baddr_in;
   logic signed [DATA_W-1:0] lb_ff, lb_in, ub_ff, ub_in;
   logic phase_ff, phase_in;
   logic [BIN_W-1:0] ci_ff, ci_in, si_ff, si_in, lo_ff, lo_in, hi_ff, hi_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic signed [NORM_W-1:0] norm_ff, norm_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic signed [SUM_W-1:0] rsp_sum_ff, rsp_sum_in;
   logic [BIN_W-1:0] rsp_lo_ff, rsp_lo_in, rsp_hi_ff, rsp_hi_in;
   logic signed [NORM_W-1:0] rsp_norm_ff, rsp_norm_in;

   logic [EAW-1:0] edge_rd_addr, edge_wr_addr;
   logic [BAW-1:0] bin_rd_addr;
   logic edge_we, bin_we, clr_all;
   logic [VW-1:0] edge_q_ff, bin_q_ff;
   logic bin_vq_ff;

   logic signed [VW-1:0] bin_val;
   logic signed [DATA_W-1:0] bound;
   logic gt, found;
   logic [BIN_W-1:0] fidx;
   func_type req_func;

   assign n_cur    = (edges_used_ff > CAP_C) ? CAP_C : edges_used_ff;
   assign bin_val  = bin_vq_ff ? $signed(bin_q_ff) : '0;
   assign bound    = phase_ff ? ub_ff : lb_ff;
   assign gt       = $signed(DATA_W'($signed(edge_q_ff))) > bound;
   assign found    = gt || ((ci_ff + 5'd1) == n_ff);
   assign fidx     = gt ? ci_ff : n_ff;
   assign req_func = func_type'(req_bus.func);

   assign req_bus.ready      = (state_ff == ST_IDLE);
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.range_sum  = rsp_sum_ff;
   assign rsp_bus.low_bin    = rsp_lo_ff;
   assign rsp_bus.high_bin   = rsp_hi_ff;
   assign rsp_bus.norm_total = rsp_norm_ff;

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      val_in       = val_ff;
      regular_in   = regular_ff;
      baddr_in     = baddr_ff;
      lb_in        = lb_ff;
      ub_in        = ub_ff;
      phase_in     = phase_ff;
      ci_in        = ci_ff;
      si_in        = si_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      sum_in       = sum_ff;
      norm_in      = norm_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_sum_in   = rsp_sum_ff;
      rsp_lo_in    = rsp_lo_ff;
      rsp_hi_in    = rsp_hi_ff;
      rsp_norm_in  = rsp_norm_ff;
      edge_rd_addr = '0;
      edge_wr_addr = EAW'(req_bus.slot_index);
      bin_rd_addr  = '0;
      edge_we      = 1'b0;
      bin_we       = 1'b0;
      clr_all      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               n_in     = n_cur;
               sum_in   = '0;
               lo_in    = '0;
               hi_in    = '0;
               val_in   = req_bus.data_value[VW-1:0];
               lb_in    = req_bus.lower_bound;
               ub_in    = req_bus.upper_bound;
               phase_in = 1'b0;
               ci_in    = '0;
               case (req_func)
                  FN_EDGE_WR: begin
                     edge_we  = (32'(req_bus.slot_index) < MAX_EDGES);
                     state_in = ST_DONE;
                  end
                  FN_BIN_WR: begin
                     if (req_bus.slot_index == '0) begin
                        regular_in = 1'b0;
                        baddr_in   = '0;
                     end else if (req_bus.slot_index < n_cur) begin
                        regular_in = 1'b1;
                        baddr_in   = BAW'(req_bus.slot_index);
                     end else begin
                        regular_in = 1'b0;
                        baddr_in   = BAW'(n_cur);
                     end
                     bin_rd_addr = baddr_in;
                     state_in    = ST_BIN;
                  end
                  FN_QUERY: begin
                     state_in = (n_cur == '0) ? ST_DONE : ST_LOC;
                  end
                  FN_CLEAR: begin
                     if (n_cur <= 5'd1) begin
                        clr_all  = 1'b1;
                        state_in = ST_DONE;
                     end else begin
                        si_in       = 5'd1;
                        bin_rd_addr = BAW'(5'd1);
                        state_in    = ST_CLR;
                     end
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_BIN: begin
            if (regular_ff) begin
               norm_in = norm_ff + NORM_W'($signed(val_ff)) - NORM_W'(bin_val);
            end
            bin_we   = 1'b1;
            state_in = ST_DONE;
         end
         ST_LOC: begin
            if (!found) begin
               ci_in        = ci_ff + 5'd1;
               edge_rd_addr = EAW'(ci_ff + 5'd1);
            end else if (!phase_ff) begin
               lo_in    = fidx;
               phase_in = 1'b1;
               ci_in    = '0;
            end else begin
               hi_in = fidx;
               if ({1'b0, fidx} > ({1'b0, lo_ff} + 6'd1)) begin
                  si_in       = lo_ff + 5'd1;
                  bin_rd_addr = BAW'(lo_ff + 5'd1);
                  state_in    = ST_SUM;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SUM: begin
            sum_in = sum_ff + SUM_W'(bin_val);
            if ((si_ff + 5'd1) == hi_ff) begin
               state_in = ST_DONE;
            end else begin
               si_in       = si_ff + 5'd1;
               bin_rd_addr = BAW'(si_ff + 5'd1);
            end
         end
         ST_CLR: begin
            norm_in = norm_ff - NORM_W'(bin_val);
            if ((si_ff + 5'd1) == n_ff) begin
               clr_all  = 1'b1;
               state_in = ST_DONE;
            end else begin
               si_in       = si_ff + 5'd1;
               bin_rd_addr = BAW'(si_ff + 5'd1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = sum_ff;
               rsp_lo_in    = lo_ff;
               rsp_hi_in    = hi_ff;
               rsp_norm_in  = norm_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         norm_ff       <= '0;
         edges_used_ff <= COUNT_W'(16);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         norm_ff      <= norm_in;
         if (csr_wr_en) begin
            edges_used_ff <= csr_wr_data;
         end
      end
      n_ff        <= n_in;
      val_ff      <= val_in;
      regular_ff  <= regular_in;
      baddr_ff    <= baddr_in;
      lb_ff       <= lb_in;
      ub_ff       <= ub_in;
      phase_ff    <= phase_in;
      ci_ff       <= ci_in;
      si_ff       <= si_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      sum_ff      <= sum_in;
      rsp_sum_ff  <= rsp_sum_in;
      rsp_lo_ff   <= rsp_lo_in;
      rsp_hi_ff   <= rsp_hi_in;
      rsp_norm_ff <= rsp_norm_in;
   end

   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_mem[edge_wr_addr] <= val_in;
      end
      edge_q_ff <= edge_mem[edge_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (bin_we) begin
         bin_mem[baddr_ff] <= val_ff;
      end
      bin_q_ff <= bin_mem[bin_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_valid_ff <= '0;
         bin_vq_ff    <= 1'b0;
      end else begin
         bin_vq_ff <= bin_valid_ff[bin_rd_addr];
         if (clr_all) begin
            bin_valid_ff <= '0;
         end else if (bin_we) begin
            bin_valid_ff[baddr_ff] <= 1'b1;
         end
      end
   end

endmodule

>>> hdl/vbhi_checker.sv
// Port-level checks for the histogram block, bound to the top level.
// Depends on variable_bin_histogram_integral_top.
module vbhi_checker #(
   parameter int MAX_EDGES = 16
) (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [35:0] range_sum,
   input logic [4:0]         low_bin,
   input logic [4:0]         high_bin,
   input logic signed [47:0] norm_total
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(range_sum) && $stable(low_bin)
         && $stable(high_bin) && $stable(norm_total))
      else $error("result changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_empty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ({1'b0, high_bin} <= ({1'b0, low_bin} + 6'd1)) |-> range_sum == '0)
      else $error("nonzero sum over empty bin range");

   a_bin_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(low_bin) <= MAX_EDGES) && (32'(high_bin) <= MAX_EDGES))
      else $error("located bin beyond table");

endmodule

bind variable_bin_histogram_integral_top vbhi_checker #(.MAX_EDGES(MAX_EDGES)) u_vbhi_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .range_sum  (rsp_bus.range_sum),
   .low_bin    (rsp_bus.low_bin),
   .high_bin   (rsp_bus.high_bin),
   .norm_total (rsp_bus.norm_total)
);
